FILE: hdl/cce_pkg.sv
package cce_pkg;

	localparam int unsigned CRC_W      = 32;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam logic [CRC_W-1:0] POLY_RESET = 32'h04C1_1DB7;

	// Input item modes; code 3 is unused and leaves the CRC untouched
	typedef enum logic [1:0] {
		MODE_SEED = 2'd0,
		MODE_BYTE = 2'd1,
		MODE_WORD = 2'd2
	} mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLY        = 2'd0,
		REG_REFLECT_IN  = 2'd1,
		REG_REFLECT_OUT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [CRC_W-1:0] poly;
		logic             reflect_in;
		logic             reflect_out;
	} cfg_t;

	function automatic logic [BYTE_W-1:0] bit_rev8(input logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int k = 0; k < BYTE_W; k++) begin
			r[k] = v[BYTE_W-1-k];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] bit_rev32(input logic [CRC_W-1:0] v);
		logic [CRC_W-1:0] r;
		for (int k = 0; k < CRC_W; k++) begin
			r[k] = v[CRC_W-1-k];
		end
		return r;
	endfunction

	// Eight MSB-first shift steps; each step is one AND/XOR level per bit
	function automatic logic [CRC_W-1:0] crc_shift8(input logic [CRC_W-1:0] c,
			input logic [CRC_W-1:0] poly);
		logic [CRC_W-1:0] r;
		r = c;
		for (int k = 0; k < BYTE_W; k++) begin
			r = {r[CRC_W-2:0], 1'b0} ^ (poly & {CRC_W{r[CRC_W-1]}});
		end
		return r;
	endfunction

endpackage

FILE: hdl/cce_next.sv
module cce_next import cce_pkg::*; (
	input  logic [CRC_W-1:0] crc_cur,
	input  logic [1:0]       mode,
	input  logic [CRC_W-1:0] data_value,
	input  cfg_t             cfg,
	output logic [CRC_W-1:0] crc_nxt
);

	logic [BYTE_W-1:0] byte_in;
	logic [CRC_W-1:0]  word_in;
	logic [CRC_W-1:0]  byte_mix;
	logic [CRC_W-1:0]  word_mix;
	logic [CRC_W-1:0]  word_p1;
	logic [CRC_W-1:0]  word_p2;
	logic [CRC_W-1:0]  word_p3;
	logic [CRC_W-1:0]  byte_res;
	logic [CRC_W-1:0]  word_res;

	assign byte_in  = cfg.reflect_in ? bit_rev8(data_value[BYTE_W-1:0])
	                                 : data_value[BYTE_W-1:0];
	assign word_in  = cfg.reflect_in ? bit_rev32(data_value) : data_value;

	assign byte_mix = crc_cur ^ {byte_in, {(CRC_W-BYTE_W){1'b0}}};
	assign word_mix = crc_cur ^ word_in;

	assign byte_res = crc_shift8(byte_mix, cfg.poly);

	// 32 shifts as four byte-wide slices
	assign word_p1  = crc_shift8(word_mix, cfg.poly);
	assign word_p2  = crc_shift8(word_p1, cfg.poly);
	assign word_p3  = crc_shift8(word_p2, cfg.poly);
	assign word_res = crc_shift8(word_p3, cfg.poly);

	always_comb begin
		unique case (mode)
			MODE_SEED: crc_nxt = data_value;
			MODE_BYTE: crc_nxt = byte_res;
			MODE_WORD: crc_nxt = word_res;
			default:   crc_nxt = crc_cur;
		endcase
	end

endmodule

FILE: hdl/configurable_crc32_engine_unit.sv
// Programmable 32-bit MSB-first CRC engine.
// Input channel (in_valid/in_stall) carries mode and data_value: mode 0 loads
// data_value as the seed, mode 1 feeds the low byte, mode 2 feeds a whole word,
// mode 3 leaves the CRC as it is. Every input transaction yields exactly one
// output transaction (out_valid/out_stall) with the running CRC in crc_raw and
// the finalized CRC in crc_final (bit-reversed when output reflection is set).
// An accepted transaction passes the input register, then the output register
// (out_valid) once the output side is free. Throughput: one transaction per
// cycle while the receiver does not stall; the byte or word CRC update is
// combinational unrolled shift logic between the input and output registers.
// If the receiver stalls, the output register holds its transaction and the
// input register still takes one more; further input is then stalled until the
// output drains.
// cfg_we/cfg_index/cfg_data write the polynomial (index 0), input reflection
// (index 1) and output reflection (index 2); write only while idle.
// Reset (arst_n low) empties both registers, clears the CRC to zero, sets the
// polynomial to 0x04C11DB7 and turns both reflections off.
module configurable_crc32_engine_unit import cce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [CRC_W-1:0]     data_value,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CRC_W-1:0]     crc_raw,
	output logic [CRC_W-1:0]     crc_final,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data
);

	cfg_t             cfg_q;
	logic [CRC_W-1:0] crc_q;
	logic             valid_s1;
	logic [1:0]       mode_s1;
	logic [CRC_W-1:0] data_s1;
	logic             valid_s2;
	logic [CRC_W-1:0] raw_s2;
	logic [CRC_W-1:0] final_s2;
	logic [CRC_W-1:0] crc_nxt;
	logic             s2_free;
	logic             s1_move;
	logic             in_take;

	assign s2_free  = !valid_s2 || !out_stall;
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly        <= POLY_RESET;
			cfg_q.reflect_in  <= 1'b0;
			cfg_q.reflect_out <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POLY:        cfg_q.poly        <= cfg_data;
				REG_REFLECT_IN:  cfg_q.reflect_in  <= cfg_data[0];
				REG_REFLECT_OUT: cfg_q.reflect_out <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			mode_s1 <= mode;
			data_s1 <= data_value;
		end
	end

	cce_next u_next (
		.crc_cur    (crc_q),
		.mode       (mode_s1),
		.data_value (data_s1),
		.cfg        (cfg_q),
		.crc_nxt    (crc_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_move) begin
				crc_q <= crc_nxt;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			raw_s2   <= crc_nxt;
			final_s2 <= cfg_q.reflect_out ? bit_rev32(crc_nxt) : crc_nxt;
		end
	end

	assign out_valid = valid_s2;
	assign crc_raw   = raw_s2;
	assign crc_final = final_s2;

endmodule

FILE: hdl/cce_checker.sv
module cce_checker import cce_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic             out_valid,
	input logic             out_stall,
	input logic [CRC_W-1:0] crc_raw,
	input logic [CRC_W-1:0] crc_final
);

	// Finalized CRC is always the raw CRC, either straight or reflected
	a_final_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (crc_final == crc_raw) || (crc_final == bit_rev32(crc_raw)))
		else $error("crc_final is neither crc_raw nor its reversal");

	// One transaction slips in behind a stalled output, then input must stall
	a_input_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall && in_valid && !in_stall) ##1 out_stall |-> in_stall)
		else $error("input accepted beyond the two-entry buffer");

	// A free output side never stalls the input
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while output register empty");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(crc_raw) && $stable(crc_final))
		else $error("stalled output transaction changed");

endmodule

bind configurable_crc32_engine_unit cce_checker u_cce_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.crc_raw   (crc_raw),
	.crc_final (crc_final)
);

FILE: sim/crc_checker.sv
module crc_checker import cce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [1:0]           mode,
	input  logic [CRC_W-1:0]     data_value,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [CRC_W-1:0]     crc_raw,
	input  logic [CRC_W-1:0]     crc_final,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CRC_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   results_seen,
	output int                   pending
);

	typedef struct packed {
		logic [CRC_W-1:0] raw;
		logic [CRC_W-1:0] fin;
	} crc_pair_t;

	crc_pair_t        crc_expected_q[$];
	cfg_t             cfg_shadow;
	logic [CRC_W-1:0] crc_shadow;

	// Reverse the low 'width' bits of v; bits above are cleared
	function automatic logic [CRC_W-1:0] mirror(input logic [CRC_W-1:0] v, input int width);
		logic [CRC_W-1:0] r;
		r = '0;
		for (int k = 0; k < width; k++) begin
			r[width-1-k] = v[k];
		end
		return r;
	endfunction

	function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] c,
			input logic [CRC_W-1:0] poly, input int steps);
		for (int k = 0; k < steps; k++) begin
			if (c[CRC_W-1]) begin
				c = (c << 1) ^ poly;
			end else begin
				c = c << 1;
			end
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		crc_pair_t        want;
		logic [CRC_W-1:0] feed;
		if (!arst_n) begin
			cfg_shadow.poly        = POLY_RESET;
			cfg_shadow.reflect_in  = 1'b0;
			cfg_shadow.reflect_out = 1'b0;
			crc_shadow             = '0;
			crc_expected_q.delete();
			mismatches             = 0;
			results_seen           = 0;
			pending                = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_POLY:        cfg_shadow.poly        = cfg_data;
					REG_REFLECT_IN:  cfg_shadow.reflect_in  = cfg_data[0];
					REG_REFLECT_OUT: cfg_shadow.reflect_out = cfg_data[0];
					default: ;
				endcase
			end

			// result side first: a transaction accepted now cannot come out at the same edge
			if (out_valid && !out_stall) begin
				results_seen++;
				if (crc_expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("[%0t] unexpected result raw=%h final=%h",
							$realtime, crc_raw, crc_final);
				end else begin
					want = crc_expected_q.pop_front();
					if (crc_raw !== want.raw || crc_final !== want.fin) begin
						mismatches++;
						if (mismatches <= 10)
							$display("[%0t] mismatch: raw exp=%h got=%h, final exp=%h got=%h",
								$realtime, want.raw, crc_raw, want.fin, crc_final);
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (mode)
					MODE_SEED: crc_shadow = data_value;
					MODE_BYTE: begin
						feed = {{(CRC_W-BYTE_W){1'b0}}, data_value[BYTE_W-1:0]};
						if (cfg_shadow.reflect_in)
							feed = mirror(feed, BYTE_W);
						crc_shadow = crc_advance(crc_shadow ^ (feed << (CRC_W - BYTE_W)),
							cfg_shadow.poly, BYTE_W);
					end
					MODE_WORD: begin
						feed = cfg_shadow.reflect_in ? mirror(data_value, CRC_W) : data_value;
						crc_shadow = crc_advance(crc_shadow ^ feed, cfg_shadow.poly, CRC_W);
					end
					default: ; // unused code: CRC held, still reported
				endcase
				want.raw = crc_shadow;
				want.fin = cfg_shadow.reflect_out ? mirror(crc_shadow, CRC_W) : crc_shadow;
				crc_expected_q.push_back(want);
			end
			pending = crc_expected_q.size();
		end
	end

endmodule

FILE: sim/tb_configurable_crc32_engine_unit.sv
module tb_configurable_crc32_engine_unit;
	import cce_pkg::*;

	localparam logic [1:0]           MODE_HOLD       = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE       = 2'd3;
	localparam int                   CYCLE_LIMIT     = 200000;
	localparam int                   PHASES          = 8;
	localparam int                   ITEMS_PER_PHASE = 210;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_stall;
	logic [1:0]           mode       = '0;
	logic [CRC_W-1:0]     data_value = '0;
	logic                 out_valid;
	logic                 out_stall  = 1'b0;
	logic [CRC_W-1:0]     crc_raw;
	logic [CRC_W-1:0]     crc_final;
	logic                 cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [CRC_W-1:0]     cfg_data   = '0;

	int   mismatches;
	int   results_seen;
	int   pending;
	int   sent_count = 0;
	int   cycles     = 0;
	int   hold_req   = 0;
	logic tx_idle    = 1'b1;
	logic rx_idle    = 1'b1;

	always #5 clk = ~clk;

	configurable_crc32_engine_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.data_value (data_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.crc_raw    (crc_raw),
		.crc_final  (crc_final),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	crc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.data_value   (data_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.crc_raw      (crc_raw),
		.crc_final    (crc_final),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.results_seen (results_seen),
		.pending      (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_configurable_crc32_engine_unit: FAIL");
			$finish;
		end
	end

	// Result side: while rx_idle, a random stall (possibly none) after each transaction, plus a long hold on request
	initial begin : receiver
		int hold_cnt;
		int wait_cnt;
		hold_cnt = 0;
		wait_cnt = 0;
		forever begin
			@(posedge clk);
			if (hold_req != 0) begin
				hold_cnt = hold_req;
				hold_req = 0;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_stall <= 1'b1;
			end else if (wait_cnt > 0) begin
				wait_cnt--;
				out_stall <= 1'b1;
			end else if (out_valid && !out_stall && rx_idle) begin
				wait_cnt = $urandom_range(0, 3);
				out_stall <= (wait_cnt != 0);
				if (wait_cnt != 0)
					wait_cnt--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(input logic [1:0] m, input logic [CRC_W-1:0] d);
		int gap;
		gap = tx_idle ? $urandom_range(0, 3) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		data_value <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_random();
		int               pick;
		logic [CRC_W-1:0] d;
		pick = $urandom_range(0, 99);
		d    = $urandom;
		case ($urandom_range(0, 15))
			0: d = '0;
			1: d = '1;
			default: ;
		endcase
		if (pick < 8)
			send_item(MODE_SEED, d);
		else if (pick < 52)
			send_item(MODE_BYTE, d);
		else if (pick < 95)
			send_item(MODE_WORD, d);
		else
			send_item(MODE_HOLD, d);
	endtask

	// Stop offering and wait until every transaction has come back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != sent_count) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [CRC_W-1:0] poly;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: polynomial 04C11DB7, no reflection
		send_item(MODE_SEED, 32'h0000_0000);
		send_item(MODE_BYTE, 32'h0000_0000);
		send_item(MODE_WORD, 32'h0000_0000);
		send_item(MODE_SEED, 32'hFFFF_FFFF);
		send_item(MODE_BYTE, 32'hFFFF_FF00); // only the low byte counts
		send_item(MODE_BYTE, 32'h0000_00FF);
		send_item(MODE_WORD, 32'hFFFF_FFFF);
		send_item(MODE_WORD, 32'h8000_0000);
		send_item(MODE_WORD, 32'h0000_0001);
		send_item(MODE_HOLD, 32'hDEAD_BEEF);
		send_item(MODE_SEED, 32'h1234_5678);
		send_item(MODE_BYTE, 32'hA5A5_A531);
		send_item(MODE_HOLD, 32'hFFFF_FFFF);
		drain();

		write_reg(REG_REFLECT_IN, 32'h0000_0001);
		write_reg(REG_REFLECT_OUT, 32'hFFFF_FFFF);
		write_reg(REG_SPARE, 32'h0000_0000); // must not touch the polynomial
		send_item(MODE_SEED, 32'hFFFF_FFFF);
		send_item(MODE_BYTE, 32'h0000_0001);
		send_item(MODE_BYTE, 32'h0000_0080);
		send_item(MODE_WORD, 32'h0000_0001);
		send_item(MODE_WORD, 32'h8000_0000);
		send_item(MODE_HOLD, 32'h0000_0000);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: poly = 32'h0000_0000;
				1: poly = 32'hFFFF_FFFF;
				2: poly = POLY_RESET;
				3: poly = 32'h1EDC_6F41;
				default: poly = $urandom;
			endcase
			write_reg(REG_POLY, poly);
			write_reg(REG_REFLECT_IN, ($urandom & 32'hFFFF_FFFE) | p[0]);
			write_reg(REG_REFLECT_OUT, ($urandom & 32'hFFFF_FFFE) | p[1]);
			if (p == 5)
				write_reg(REG_SPARE, $urandom);

			if (p == 2) begin
				// long output hold with back-to-back input: pipeline fills, input stalls
				tx_idle  = 1'b0;
				hold_req = 40;
				repeat (12) send_random();
			end

			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (i % 50 == 0) begin
					tx_idle = ($urandom_range(0, 2) != 0);
					rx_idle = ($urandom_range(0, 2) != 0);
				end
				if ($urandom_range(0, 99) == 0)
					drain();
				send_random();
			end
			drain();
		end

		repeat (4) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb_configurable_crc32_engine_unit: PASS");
		end else begin
			$display("tb_configurable_crc32_engine_unit: FAIL");
		end
		$finish;
	end

endmodule

FILE: sim.f
hdl/cce_pkg.sv
hdl/cce_next.sv
hdl/configurable_crc32_engine_unit.sv
hdl/cce_checker.sv
sim/crc_checker.sv
sim/tb_configurable_crc32_engine_unit.sv
